// File: src/apgs_pkg.sv
// Shared types and constants for the allele pair genotype scorer.
// Used by apgs_site_score and allele_pair_genotype_scorer; depends on nothing.
package apgs_pkg;

	localparam int PROB_FRAC_BITS = 16;
	localparam int PENALTY_BITS   = 30;
	localparam int PROB_W         = 16;
	localparam int SCORE_W        = PROB_W + 2;
	localparam int BASE_W         = 3;
	localparam int ALLELE_W       = 2;
	localparam int PAIR_W         = 16;

	localparam logic [PROB_W:0]         ONE_VAL = (PROB_W + 1)'(1) << PROB_FRAC_BITS;
	localparam logic [PENALTY_BITS-1:0] PEN_MAX = '1;

	localparam logic [BASE_W-1:0] BASE_ABSENT = 3'd4;
	localparam logic [BASE_W-1:0] BASE_GAP    = 3'd5;
	localparam logic [BASE_W-1:0] BASE_T      = 3'd3;

	localparam logic [0:0] CFG_STRAND = 1'b0;
	localparam logic [0:0] CFG_PRUNE  = 1'b1;

	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic               skip;
	} site_t;

	typedef struct packed {
		logic [PENALTY_BITS-1:0] pair_penalty;
		logic                    pair_pruned;
		logic                    improved;
		logic [PENALTY_BITS-1:0] best_penalty;
		logic [PAIR_W-1:0]       best_pair;
		logic                    best_valid;
	} result_t;

endpackage

// File: src/apgs_site_score.sv
// Combinational score of one site: base decode, allele complement and genotype rules.
// Depends on apgs_pkg.
module apgs_site_score (
	input  logic                                  strand_complement,
	input  logic [apgs_pkg::BASE_W-1:0]           first_base,
	input  logic [apgs_pkg::BASE_W-1:0]           second_base,
	input  logic [apgs_pkg::BASE_W-1:0]           reference_base,
	input  logic [apgs_pkg::ALLELE_W-1:0]         allele_one,
	input  logic [apgs_pkg::ALLELE_W-1:0]         allele_two,
	input  logic [apgs_pkg::BASE_W-1:0]           allele_three,
	input  logic [2*apgs_pkg::PROB_W-1:0]         probs_first_two,
	input  logic [2*apgs_pkg::PROB_W-1:0]         probs_middle_two,
	input  logic [2*apgs_pkg::PROB_W-1:0]         probs_last_two,
	output apgs_pkg::site_t                       site
);

	localparam int SW = apgs_pkg::SCORE_W;
	localparam int PW = apgs_pkg::PROB_W;

	logic [apgs_pkg::BASE_W-1:0] h1, h2, h, a1, a2, a3;
	logic                        three, ok1, ok2, abs1, abs2;
	logic [SW-1:0]               p0, p1, p2, p3, p4, p5;
	logic [SW-1:0]               score;

	function automatic logic [apgs_pkg::BASE_W-1:0] decode_base(
		input logic [apgs_pkg::BASE_W-1:0] b,
		input logic [apgs_pkg::BASE_W-1:0] ref_b
	);
		logic [apgs_pkg::BASE_W-1:0] v;
		v = (b == apgs_pkg::BASE_GAP) ? ref_b : b;
		return (v <= apgs_pkg::BASE_T) ? v : apgs_pkg::BASE_ABSENT;
	endfunction

	// One minus p, clamped at zero.
	function automatic logic [SW-1:0] inv_prob(input logic [SW-1:0] p);
		logic [SW-1:0] one_w;
		one_w = SW'(apgs_pkg::ONE_VAL);
		return (p >= one_w) ? '0 : one_w - p;
	endfunction

	function automatic logic is_pair(
		input logic [apgs_pkg::BASE_W-1:0] x1,
		input logic [apgs_pkg::BASE_W-1:0] x2,
		input logic [apgs_pkg::BASE_W-1:0] x,
		input logic [apgs_pkg::BASE_W-1:0] y
	);
		return (x1 == x && x2 == y) || (x1 == y && x2 == x);
	endfunction

	always_comb begin
		h1    = decode_base(first_base, reference_base);
		h2    = decode_base(second_base, reference_base);
		three = ~allele_three[2];
		if (strand_complement) begin
			a1 = {1'b0, ~allele_one};
			a2 = {1'b0, ~allele_two};
			a3 = three ? {1'b0, ~allele_three[1:0]} : allele_three;
		end else begin
			a1 = {1'b0, allele_one};
			a2 = {1'b0, allele_two};
			a3 = allele_three;
		end
		p0 = SW'(probs_first_two[PW-1:0]);
		p1 = SW'(probs_first_two[2*PW-1:PW]);
		p2 = SW'(probs_middle_two[PW-1:0]);
		p3 = SW'(probs_middle_two[2*PW-1:PW]);
		p4 = SW'(probs_last_two[PW-1:0]);
		p5 = SW'(probs_last_two[2*PW-1:PW]);

		abs1 = (h1 == apgs_pkg::BASE_ABSENT);
		abs2 = (h2 == apgs_pkg::BASE_ABSENT);
		ok1  = abs1 || h1 == a1 || h1 == a2 || (three && h1 == a3);
		ok2  = abs2 || h2 == a1 || h2 == a2 || (three && h2 == a3);
		h    = abs1 ? h2 : h1;

		if (!(ok1 && ok2)) begin
			score = SW'(apgs_pkg::ONE_VAL);
		end else if (abs1 || abs2) begin
			// A single base present: the sum over genotypes that miss it.
			if (!three) begin
				if (h == a1)      score = p2;
				else if (h == a2) score = p0;
				else              score = '0;
			end else begin
				if (h == a1)      score = p2 + p4 + p5;
				else if (h == a2) score = p0 + p3 + p5;
				else if (h == a3) score = p0 + p1 + p2;
				else              score = '0;
			end
		end else if (!three) begin
			if (is_pair(h1, h2, a1, a2))      score = p0 + p2;
			else if (h1 == a1 && h2 == a1)    score = p1 + p2;
			else if (h1 == a2 && h2 == a2)    score = p0 + p1;
			else                              score = '0;
		end else begin
			if (is_pair(h1, h2, a1, a2))      score = inv_prob(p1);
			else if (is_pair(h1, h2, a3, a2)) score = inv_prob(p4);
			else if (is_pair(h1, h2, a1, a3)) score = inv_prob(p3);
			else if (h1 == a1 && h2 == a1)    score = inv_prob(p0);
			else if (h1 == a2 && h2 == a2)    score = inv_prob(p2);
			else if (h1 == a3 && h2 == a3)    score = inv_prob(p5);
			else                              score = '0;
		end

		site.score = score;
		site.skip  = abs1 && abs2;
	end

endmodule

// File: src/allele_pair_genotype_scorer.sv
// Top level of the allele pair genotype scorer: input register, penalty and best-pair
// state, and a two-entry result buffer. Depends on apgs_pkg and apgs_site_score.
//
//  channel | handshake               | payload
//  --------+-------------------------+-----------------------------------------------
//  in      | in_valid / in_stall     | start_search .. probs_last_two, one site
//  out     | out_valid / out_stall   | pair_penalty .. best_valid, one per pair
//  cfg     | cfg_we                  | cfg_index, cfg_data
//
// One item per cycle while in_stall is low. An item is registered on acceptance and is
// scored from the input register while in_stall is low; at the end of that cycle the penalty
// and best-pair registers take it and a last-of-pair item loads its result into the buffer.
// The accumulate, prune compare and best compare form the loop that limits the item rate.
// in_stall rises only while a last-of-pair item waits in the input register and both
// result entries are full, so out_stall reaches in_stall only through registers.
// arst_n clears the valid flags and the penalty and best-pair state, sets prune_enable and clears strand_complement.
module allele_pair_genotype_scorer (
	input  logic                                 clk,
	input  logic                                 arst_n,

	input  logic                                 cfg_we,
	input  logic                                 cfg_index,
	input  logic                                 cfg_data,

	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 start_search,
	input  logic                                 last_of_pair,
	input  logic [apgs_pkg::PAIR_W-1:0]          pair_index,
	input  logic [apgs_pkg::BASE_W-1:0]          first_base,
	input  logic [apgs_pkg::BASE_W-1:0]          second_base,
	input  logic [apgs_pkg::BASE_W-1:0]          reference_base,
	input  logic [apgs_pkg::ALLELE_W-1:0]        allele_one,
	input  logic [apgs_pkg::ALLELE_W-1:0]        allele_two,
	input  logic [apgs_pkg::BASE_W-1:0]          allele_three,
	input  logic [2*apgs_pkg::PROB_W-1:0]        probs_first_two,
	input  logic [2*apgs_pkg::PROB_W-1:0]        probs_middle_two,
	input  logic [2*apgs_pkg::PROB_W-1:0]        probs_last_two,

	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [apgs_pkg::PENALTY_BITS-1:0]    pair_penalty,
	output logic                                 pair_pruned,
	output logic                                 improved,
	output logic [apgs_pkg::PENALTY_BITS-1:0]    best_penalty,
	output logic [apgs_pkg::PAIR_W-1:0]          best_pair,
	output logic                                 best_valid
);

	localparam int PB = apgs_pkg::PENALTY_BITS;

	// Configuration registers.
	logic strand_q, prune_en_q;

	// Input register.
	logic                               valid_s1;
	logic                               start_s1, last_s1;
	logic [apgs_pkg::PAIR_W-1:0]        pair_s1;
	logic [apgs_pkg::BASE_W-1:0]        first_s1, second_s1, ref_s1, a3_s1;
	logic [apgs_pkg::ALLELE_W-1:0]      a1_s1, a2_s1;
	logic [2*apgs_pkg::PROB_W-1:0]      pf_s1, pm_s1, pl_s1;

	// Pair and search state.
	logic [PB-1:0]                      run_q, best_score_q;
	logic                               pruned_q, best_seen_q;
	logic [apgs_pkg::PAIR_W-1:0]        best_id_q;

	// Result buffer.
	logic                               main_v_q, skid_v_q;
	apgs_pkg::result_t                  main_q, skid_q;

	apgs_pkg::site_t                    site;
	apgs_pkg::result_t                  res;
	logic                               accept, process, push, pop;
	logic [PB-1:0]                      eff_run, eff_best, new_run;
	logic [apgs_pkg::PAIR_W-1:0]        eff_id;
	logic                               eff_pruned, eff_seen, pr, better;
	logic [PB:0]                        sum;

	apgs_site_score u_site (
		.strand_complement (strand_q),
		.first_base        (first_s1),
		.second_base       (second_s1),
		.reference_base    (ref_s1),
		.allele_one        (a1_s1),
		.allele_two        (a2_s1),
		.allele_three      (a3_s1),
		.probs_first_two   (pf_s1),
		.probs_middle_two  (pm_s1),
		.probs_last_two    (pl_s1),
		.site              (site)
	);

	assign in_stall = valid_s1 && last_s1 && skid_v_q;
	assign accept   = in_valid && !in_stall;
	assign process  = valid_s1 && !in_stall;
	assign push     = process && last_s1;
	assign pop      = main_v_q && !out_stall;

	always_comb begin
		// A new search clears both the best pair and the running pair.
		eff_run    = start_s1 ? '0 : run_q;
		eff_pruned = start_s1 ? 1'b0 : pruned_q;
		eff_best   = start_s1 ? '0 : best_score_q;
		eff_id     = start_s1 ? '0 : best_id_q;
		eff_seen   = start_s1 ? 1'b0 : best_seen_q;

		pr  = eff_pruned || (prune_en_q && eff_seen && eff_run > eff_best);
		sum = {1'b0, eff_run} + (PB + 1)'(site.score);
		if (pr || site.skip)
			new_run = eff_run;
		else if (sum[PB])
			new_run = apgs_pkg::PEN_MAX;
		else
			new_run = sum[PB-1:0];

		better = !eff_seen || new_run < eff_best;

		res.pair_penalty = new_run;
		res.pair_pruned  = pr;
		res.improved     = better;
		res.best_penalty = better ? new_run : eff_best;
		res.best_pair    = better ? pair_s1 : eff_id;
		res.best_valid   = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strand_q   <= 1'b0;
			prune_en_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				apgs_pkg::CFG_STRAND: strand_q   <= cfg_data;
				apgs_pkg::CFG_PRUNE:  prune_en_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (process) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			start_s1  <= start_search;
			last_s1   <= last_of_pair;
			pair_s1   <= pair_index;
			first_s1  <= first_base;
			second_s1 <= second_base;
			ref_s1    <= reference_base;
			a1_s1     <= allele_one;
			a2_s1     <= allele_two;
			a3_s1     <= allele_three;
			pf_s1     <= probs_first_two;
			pm_s1     <= probs_middle_two;
			pl_s1     <= probs_last_two;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q        <= '0;
			pruned_q     <= 1'b0;
			best_score_q <= '0;
			best_id_q    <= '0;
			best_seen_q  <= 1'b0;
		end else if (process) begin
			if (last_s1) begin
				run_q        <= '0;
				pruned_q     <= 1'b0;
				best_score_q <= res.best_penalty;
				best_id_q    <= res.best_pair;
				best_seen_q  <= 1'b1;
			end else begin
				run_q        <= new_run;
				pruned_q     <= pr;
				best_score_q <= eff_best;
				best_id_q    <= eff_id;
				best_seen_q  <= eff_seen;
			end
		end
	end

	// Two-entry result buffer: the skid entry fills only while the main entry is held.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!main_v_q || pop) begin
			if (skid_v_q) begin
				main_v_q <= 1'b1;
				skid_v_q <= push;
			end else begin
				main_v_q <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!main_v_q || pop) begin
			main_q <= skid_v_q ? skid_q : res;
			if (skid_v_q && push)
				skid_q <= res;
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign out_valid    = main_v_q;
	assign pair_penalty = main_q.pair_penalty;
	assign pair_pruned  = main_q.pair_pruned;
	assign improved     = main_q.improved;
	assign best_penalty = main_q.best_penalty;
	assign best_pair    = main_q.best_pair;
	assign best_valid   = main_q.best_valid;

endmodule
